### src/hmacs_pkg.sv
package hmacs_pkg;

   localparam int KeyBytes = 32;
   localparam int BlockBytes = 64;
   localparam int KeyLimit = (KeyBytes < 32) ? KeyBytes : 32;

   localparam logic [7:0] InnerPad = 8'h36;
   localparam logic [7:0] OuterPad = 8'h5c;
   localparam logic [7:0] PadMarker = 8'h80;
   localparam logic [5:0] KeyLengthReset = 6'd32;

   typedef enum logic [2:0] {
      CSR_KEY_WORD_0 = 3'd0,
      CSR_KEY_WORD_1 = 3'd1,
      CSR_KEY_WORD_2 = 3'd2,
      CSR_KEY_WORD_3 = 3'd3,
      CSR_KEY_LENGTH = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic start;
      logic bank;
      logic fresh;   // chain entries read as the initial hash value
   } cmp_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cmp_stat_type;

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

   function automatic logic [31:0] sha_iv_word(input logic [2:0] idx);
      logic [31:0] h;
      case (idx)
         3'd0: h = 32'h6a09e667;
         3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372;
         3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f;
         3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab;
         default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      case (t)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

endpackage

### src/hmacs_ram.sv
module hmacs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/hmacs_compress.sv
module hmacs_compress (
   input  logic                    clock,
   input  logic                    reset,
   input  hmacs_pkg::cmp_ctrl_type ctrl,
   output hmacs_pkg::cmp_stat_type stat,
   output logic [3:0]              blk_raddr,
   input  logic [31:0]             blk_rdata,
   input  logic [3:0]              ext_raddr,
   output logic [31:0]             chain_rdata
);

   typedef enum logic [3:0] {
      C_IDLE  = 4'b0001,
      C_LOAD  = 4'b0010,
      C_ROUND = 4'b0100,
      C_FINAL = 4'b1000
   } cstate_type;

   cstate_type  state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic        bank_ff, bank_in;
   logic        fresh_ff, fresh_in;
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];

   logic [2:0]  step_idx;
   logic [31:0] prev_word;
   logic [31:0] w_cur;
   logic [31:0] t1;
   logic [31:0] t2;
   logic        wr_en;
   logic [3:0]  rd_addr;

   // chain value, two banks of eight words: inner pass and outer pass
   hmacs_ram #(.WIDTH(32), .DEPTH(16)) u_chain (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({bank_ff, step_idx}),
      .wr_data (prev_word + v_ff[step_idx]),
      .rd_addr (rd_addr),
      .rd_data (chain_rdata)
   );

   // step n reads entry n; its data lands at step n+1
   assign step_idx  = cnt_ff[2:0] - 3'd1;
   assign prev_word = fresh_ff ? hmacs_pkg::sha_iv_word(step_idx) : chain_rdata;
   assign rd_addr   = (state_ff == C_LOAD || state_ff == C_FINAL) ?
                      {bank_ff, cnt_ff[2:0]} : ext_raddr;
   assign wr_en     = (state_ff == C_FINAL) && (cnt_ff != 4'd0);
   assign blk_raddr = (state_ff == C_ROUND) ? (rnd_ff[3:0] + 4'd1) : 4'd0;

   assign w_cur = (rnd_ff < 6'd16) ? blk_rdata :
                  hmacs_pkg::small_sigma1(win_ff[14]) + win_ff[9] +
                  hmacs_pkg::small_sigma0(win_ff[1]) + win_ff[0];
   assign t1 = v_ff[7] + hmacs_pkg::big_sigma1(v_ff[4]) +
               ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) +
               hmacs_pkg::round_k(rnd_ff) + w_cur;
   assign t2 = hmacs_pkg::big_sigma0(v_ff[0]) +
               ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   assign stat.busy = (state_ff != C_IDLE);
   assign stat.done = (state_ff == C_FINAL) && (cnt_ff == 4'd8);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rnd_in   = rnd_ff;
      bank_in  = bank_ff;
      fresh_in = fresh_ff;
      v_in     = v_ff;
      win_in   = win_ff;
      case (state_ff)
         C_IDLE: begin
            if (ctrl.start) begin
               state_in = C_LOAD;
               cnt_in   = 4'd0;
               bank_in  = ctrl.bank;
               fresh_in = ctrl.fresh;
            end
         end
         C_LOAD: begin
            if (cnt_ff != 4'd0) begin
               v_in[step_idx] = prev_word;
            end
            if (cnt_ff == 4'd8) begin
               state_in = C_ROUND;
               rnd_in   = 6'd0;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         C_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[15] = w_cur;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = C_FINAL;
               cnt_in   = 4'd0;
            end
         end
         C_FINAL: begin
            if (cnt_ff == 4'd8) begin
               state_in = C_IDLE;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      rnd_ff   <= rnd_in;
      bank_ff  <= bank_in;
      fresh_ff <= fresh_in;
      v_ff     <= v_in;
      win_ff   <= win_in;
   end

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> (state_ff == C_IDLE))
      else $error("compression did not return to idle after write-back");

   a_round_after_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == C_ROUND && rnd_ff == 6'd0) |-> ($past(state_ff) == C_LOAD))
      else $error("rounds started without loading working variables");

   a_wb_only_final: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (cnt_ff <= 4'd8 && state_ff == C_FINAL))
      else $error("chain write outside write-back");

endmodule

### src/hmac_sha256_engine_top.sv
// HMAC-SHA256 engine. The key (up to 32 bytes) sits in csr registers 0..3,
// first byte in the most significant bits, with its byte count in register 4.
// Write them only while the block is idle; csr_write takes effect at once.
// Request channel: one transaction per message byte (req_byte_present) and
// req_last on the final one; a transaction with no byte and last set yields
// the MAC of the empty message. The response channel carries one 256-bit MAC
// per message, on the transaction that had last set.
// Flow: each 64-byte block costs one compression (8 chain reads, 64 rounds
// at one round per cycle, 8 chain write-backs through the chain-value RAM).
// A byte that does not fill a block passes through S_MSG and S_CHK and the
// block is back in idle. The first transaction of a message adds 64 pad bytes
// and one compression; the last adds padding, the outer pad and the digest,
// three or four compressions in all, then reads the MAC out of the chain RAM
// word by word through S_ORD and S_OCAP.
// One transaction is in work at a time; req_stall is high while it is.
// A MAC waiting on a stalled response does not block the next messages'
// bytes; only the next MAC read-out waits for it to be taken.
// Reset is synchronous: key cleared, key length 32, a new message begins,
// and no response is pending. No clearing pass is needed.
module hmac_sha256_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_mac_word_0,
   output logic [63:0] rsp_mac_word_1,
   output logic [63:0] rsp_mac_word_2,
   output logic [63:0] rsp_mac_word_3,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   typedef enum logic [15:0] {
      S_IDLE    = 16'h0001,
      S_IPAD    = 16'h0002,
      S_MSG     = 16'h0004,
      S_CHK     = 16'h0008,
      S_WAIT    = 16'h0010,
      S_PAD80   = 16'h0020,
      S_PADZ    = 16'h0040,
      S_LEN     = 16'h0080,
      S_PASSEND = 16'h0100,
      S_OPAD    = 16'h0200,
      S_DRD     = 16'h0400,
      S_DLD     = 16'h0800,
      S_DFEED   = 16'h1000,
      S_OUTW    = 16'h2000,
      S_ORD     = 16'h4000,
      S_OCAP    = 16'h8000
   } state_type;

   state_type   state_ff, state_in;
   state_type   ret_ff, ret_in;
   logic        phase_ff, phase_in;
   logic        outer_ff, outer_in;
   logic        fresh_ff, fresh_in;
   logic [63:0] msglen_ff, msglen_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [2:0]  wcnt_ff, wcnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] key_word_ff [4];
   logic [5:0]  key_len_ff;

   logic [7:0]   in_byte_ff, in_byte_in;
   logic         in_present_ff, in_present_in;
   logic         in_last_ff, in_last_in;
   logic [23:0]  word_ff, word_in;
   logic [63:0]  bits_ff, bits_in;
   logic [31:0]  dword_ff, dword_in;
   logic [255:0] mac_ff, mac_in;

   logic        feed_en;
   logic [7:0]  feed_byte;
   logic        blk_wr_en;
   logic [3:0]  blk_raddr;
   logic [31:0] blk_rdata;
   logic [3:0]  ext_raddr;
   logic [31:0] chain_rdata;
   logic [5:0]  klen;
   logic [5:0]  kshift;
   logic [7:0]  kbyte;
   logic        wrap;

   hmacs_pkg::cmp_ctrl_type cmp_ctrl;
   hmacs_pkg::cmp_stat_type cmp_stat;

   hmacs_ram #(.WIDTH(32), .DEPTH(16)) u_block (
      .clock   (clock),
      .wr_en   (blk_wr_en),
      .wr_addr (msglen_ff[5:2]),
      .wr_data ({word_ff, feed_byte}),
      .rd_addr (blk_raddr),
      .rd_data (blk_rdata)
   );

   hmacs_compress u_compress (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (cmp_ctrl),
      .stat        (cmp_stat),
      .blk_raddr   (blk_raddr),
      .blk_rdata   (blk_rdata),
      .ext_raddr   (ext_raddr),
      .chain_rdata (chain_rdata)
   );

   assign klen   = (key_len_ff > 6'(hmacs_pkg::KeyLimit)) ?
                   6'(hmacs_pkg::KeyLimit) : key_len_ff;
   assign kshift = {~cnt_ff[2:0], 3'b000};
   assign kbyte  = (cnt_ff < klen) ? key_word_ff[cnt_ff[4:3]][kshift +: 8] : 8'd0;

   // a byte at block offset 63 completes the block and starts a compression
   assign wrap      = (msglen_ff[5:0] == 6'd63);
   assign blk_wr_en = feed_en && (msglen_ff[1:0] == 2'd3);

   assign cmp_ctrl.start = feed_en && wrap;
   assign cmp_ctrl.bank  = outer_ff;
   assign cmp_ctrl.fresh = fresh_ff;

   assign ext_raddr = (state_ff == S_ORD) ? {1'b1, wcnt_ff} : {1'b0, wcnt_ff};

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mac_word_0 = mac_ff[255:192];
   assign rsp_mac_word_1 = mac_ff[191:128];
   assign rsp_mac_word_2 = mac_ff[127:64];
   assign rsp_mac_word_3 = mac_ff[63:0];

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      phase_in      = phase_ff;
      outer_in      = outer_ff;
      fresh_in      = fresh_ff;
      msglen_in     = msglen_ff;
      cnt_in        = cnt_ff;
      wcnt_in       = wcnt_ff;
      in_byte_in    = in_byte_ff;
      in_present_in = in_present_ff;
      in_last_in    = in_last_ff;
      bits_in       = bits_ff;
      dword_in      = dword_ff;
      mac_in        = mac_ff;
      feed_en       = 1'b0;
      feed_byte     = 8'd0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               in_byte_in    = req_data_byte;
               in_present_in = req_byte_present;
               in_last_in    = req_last;
               if (!phase_ff) begin
                  state_in = S_IPAD;
                  cnt_in   = 6'd0;
                  phase_in = 1'b1;
                  fresh_in = 1'b1;
               end else begin
                  state_in = S_MSG;
               end
            end
         end
         S_IPAD: begin
            feed_en   = 1'b1;
            feed_byte = kbyte ^ hmacs_pkg::InnerPad;
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = S_WAIT;
               ret_in   = S_MSG;
            end
         end
         S_MSG: begin
            feed_en   = in_present_ff;
            feed_byte = in_byte_ff;
            if (in_present_ff && wrap) begin
               state_in = S_WAIT;
               ret_in   = S_CHK;
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            state_in = in_last_ff ? S_PAD80 : S_IDLE;
         end
         S_WAIT: begin
            if (cmp_stat.done) begin
               state_in = ret_ff;
               fresh_in = 1'b0;
            end
         end
         S_PAD80: begin
            bits_in   = {msglen_ff[60:0], 3'b000};
            feed_en   = 1'b1;
            feed_byte = hmacs_pkg::PadMarker;
            if (wrap) begin
               state_in = S_WAIT;
               ret_in   = S_PADZ;
            end else begin
               state_in = S_PADZ;
            end
         end
         S_PADZ: begin
            if (msglen_ff[5:0] == 6'd56) begin
               state_in = S_LEN;
               cnt_in   = 6'd0;
            end else begin
               feed_en = 1'b1;
               if (wrap) begin
                  state_in = S_WAIT;
                  ret_in   = S_PADZ;
               end
            end
         end
         S_LEN: begin
            feed_en   = 1'b1;
            feed_byte = bits_ff[63:56];
            bits_in   = {bits_ff[55:0], 8'd0};
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff[2:0] == 3'd7) begin
               state_in = S_WAIT;
               ret_in   = S_PASSEND;
            end
         end
         S_PASSEND: begin
            if (!outer_ff) begin
               state_in  = S_OPAD;
               outer_in  = 1'b1;
               fresh_in  = 1'b1;
               msglen_in = 64'd0;
               cnt_in    = 6'd0;
            end else begin
               state_in = S_OUTW;
            end
         end
         S_OPAD: begin
            feed_en   = 1'b1;
            feed_byte = kbyte ^ hmacs_pkg::OuterPad;
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = S_WAIT;
               ret_in   = S_DRD;
               wcnt_in  = 3'd0;
            end
         end
         S_DRD: begin
            state_in = S_DLD;
         end
         S_DLD: begin
            dword_in = chain_rdata;
            cnt_in   = 6'd0;
            state_in = S_DFEED;
         end
         S_DFEED: begin
            feed_en   = 1'b1;
            feed_byte = dword_ff[31:24];
            dword_in  = {dword_ff[23:0], 8'd0};
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               if (wcnt_ff == 3'd7) begin
                  state_in = S_PAD80;
               end else begin
                  wcnt_in  = wcnt_ff + 3'd1;
                  state_in = S_DRD;
               end
            end
         end
         S_OUTW: begin
            // previous MAC must be gone before the output register is reused
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_ORD;
               wcnt_in  = 3'd0;
            end
         end
         S_ORD: begin
            state_in = S_OCAP;
         end
         S_OCAP: begin
            mac_in = {mac_ff[223:0], chain_rdata};
            if (wcnt_ff == 3'd7) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               phase_in     = 1'b0;
               outer_in     = 1'b0;
               msglen_in    = 64'd0;
            end else begin
               wcnt_in  = wcnt_ff + 3'd1;
               state_in = S_ORD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (feed_en) begin
         msglen_in = msglen_ff + 64'd1;
      end
   end

   assign word_in = feed_en ? {word_ff[15:0], feed_byte} : word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         phase_ff     <= 1'b0;
         outer_ff     <= 1'b0;
         fresh_ff     <= 1'b0;
         msglen_ff    <= 64'd0;
         rsp_valid_ff <= 1'b0;
         key_len_ff   <= hmacs_pkg::KeyLengthReset;
         for (int i = 0; i < 4; i++) begin
            key_word_ff[i] <= 64'd0;
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         phase_ff     <= phase_in;
         outer_ff     <= outer_in;
         fresh_ff     <= fresh_in;
         msglen_ff    <= msglen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               hmacs_pkg::CSR_KEY_WORD_0: key_word_ff[0] <= csr_data;
               hmacs_pkg::CSR_KEY_WORD_1: key_word_ff[1] <= csr_data;
               hmacs_pkg::CSR_KEY_WORD_2: key_word_ff[2] <= csr_data;
               hmacs_pkg::CSR_KEY_WORD_3: key_word_ff[3] <= csr_data;
               hmacs_pkg::CSR_KEY_LENGTH: key_len_ff <= csr_data[5:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      wcnt_ff       <= wcnt_in;
      in_byte_ff    <= in_byte_in;
      in_present_ff <= in_present_in;
      in_last_ff    <= in_last_in;
      word_ff       <= word_in;
      bits_ff       <= bits_in;
      dword_ff      <= dword_in;
      mac_ff        <= mac_in;
   end

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmp_ctrl.start |-> !cmp_stat.busy)
      else $error("compression started while one is in progress");

   a_no_feed_busy: assert property (@(posedge clock) disable iff (reset)
      feed_en |-> !cmp_stat.busy)
      else $error("block buffer written during compression");

   a_clean_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !phase_ff) |-> (msglen_ff == 64'd0 && !outer_ff))
      else $error("message state not cleared between messages");

endmodule

### dv/hmac_sha256_engine_top_tb.sv
`timescale 1ns / 1ps

module hmac_sha256_engine_top_tb;

   localparam int CycleLimit = 1000000;
   localparam int ItemTarget = 1450;
   localparam int DrainCycles = 700;

   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       last;
   } msg_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_byte_present = 1'b0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_mac_word_0, rsp_mac_word_1, rsp_mac_word_2, rsp_mac_word_3;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   hmac_sha256_engine_top dut (.*);

   always #10 clock = ~clock;

   msg_item_type      pending_items[$];
   logic [3:0][63:0]  mac_queue[$];
   int unsigned       error_count = 0;
   int unsigned       cycle_count = 0;
   int unsigned       items_queued = 0;
   bit                quiet_tx = 0;
   bit                quiet_rx = 0;

   // mirror of the key registers and of the hash state
   logic [63:0] key_reg[4];
   logic [5:0]  key_len_reg;
   logic [31:0] hash_v[8];
   logic [7:0]  blk[64];
   logic [63:0] byte_count;
   bit          in_message;

   function automatic logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] rk(int t);
      logic [31:0] k[64];
      k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[t];
   endfunction

   task automatic sha_compress();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int t = 16; t < 64; t++)
         w[t] = w[t-16] + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
                + w[t-7] + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
      v = hash_v;
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + rk(t) + w[t];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_v[i] += v[i];
   endtask

   task automatic hash_byte(logic [7:0] b);
      blk[byte_count[5:0]] = b;
      byte_count++;
      if (byte_count[5:0] == 6'd0) sha_compress();
   endtask

   // new SHA-256 pass seeded with the zero-padded key xor pad
   task automatic pad_pass(logic [7:0] pad);
      int klen;
      klen = int'(key_len_reg);
      if (klen > hmacs_pkg::KeyLimit) klen = hmacs_pkg::KeyLimit;
      hash_v = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      for (int i = 0; i < 64; i++)
         blk[i] = ((i < klen) ? key_reg[i/8][63-8*(i%8) -: 8] : 8'h00) ^ pad;
      sha_compress();
      byte_count = 64;
   endtask

   task automatic close_pass();
      logic [63:0] bits;
      int idx;
      bits = byte_count << 3;
      idx = int'(byte_count[5:0]);
      blk[idx] = 8'h80;
      idx++;
      if (idx > 56) begin
         while (idx < 64) begin
            blk[idx] = 8'h00;
            idx++;
         end
         sha_compress();
         idx = 0;
      end
      while (idx < 56) begin
         blk[idx] = 8'h00;
         idx++;
      end
      for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
      sha_compress();
   endtask

   task automatic predict_mac(msg_item_type it);
      logic [31:0] inner[8];
      logic [3:0][63:0] mac;
      if (!in_message) begin
         pad_pass(hmacs_pkg::InnerPad);
         in_message = 1;
      end
      if (it.present) hash_byte(it.data);
      if (it.last) begin
         close_pass();
         inner = hash_v;
         pad_pass(hmacs_pkg::OuterPad);
         for (int i = 0; i < 32; i++) hash_byte(inner[i/4][31-8*(i%4) -: 8]);
         close_pass();
         for (int i = 0; i < 4; i++) mac[i] = {hash_v[2*i], hash_v[2*i+1]};
         mac_queue.push_back(mac);
         in_message = 0;
         byte_count = 0;
      end
   endtask

   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // driver
   int tx_gap = 0;
   always @(posedge clock) begin
      msg_item_type it;
      msg_item_type seen;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            seen.data = req_data_byte;
            seen.present = req_byte_present;
            seen.last = req_last;
            predict_mac(seen);
         end
         if (tx_gap > 0) begin
            tx_gap--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            req_data_byte <= it.data;
            req_byte_present <= it.present;
            req_last <= it.last;
            req_valid <= 1'b1;
            tx_gap = pick_gap(quiet_tx);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   int rx_gap = 0;
   always @(posedge clock) begin
      logic [3:0][63:0] want, got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_mac_word_3, rsp_mac_word_2, rsp_mac_word_1, rsp_mac_word_0};
            if (mac_queue.size() == 0) begin
               $display("%0t: unexpected MAC transaction %h", $time, got);
               error_count++;
            end else begin
               want = mac_queue.pop_front();
               for (int i = 0; i < 4; i++)
                  if (want[i] !== got[i]) begin
                     $display("%0t: mac_word_%0d expected %h actual %h",
                              $time, i, want[i], got[i]);
                     error_count++;
                  end
            end
         end
         if (rx_gap > 0) begin
            rx_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            rx_gap = pick_gap(quiet_rx);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic csr_put(hmacs_pkg::csr_index_type idx, logic [63:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      if (idx <= hmacs_pkg::CSR_KEY_WORD_3) key_reg[idx[1:0]] = value;
      else if (idx == hmacs_pkg::CSR_KEY_LENGTH) key_len_reg = value[5:0];
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // block idle: nothing queued or expected and the last transaction finished
   task automatic wait_idle();
      while (pending_items.size() > 0 || req_valid || mac_queue.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      while (req_stall) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic add_item(logic [7:0] d, bit present, bit last);
      msg_item_type it;
      it.data = d;
      it.present = present;
      it.last = last;
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic add_message(int n, int blank_pct);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < blank_pct) add_item(8'($urandom), 0, 0);
         add_item(8'($urandom), 1, (i == n - 1));
      end
      if (n == 0) add_item(8'($urandom), 0, 1);
   endtask

   task automatic random_key();
      int r;
      r = $urandom_range(0, 9);
      for (int i = 0; i < 4; i++)
         csr_put(hmacs_pkg::csr_index_type'(i), (r == 0) ? 64'd0 : (r == 1) ? '1 :
                 {$urandom, $urandom});
      r = $urandom_range(0, 9);
      csr_put(hmacs_pkg::CSR_KEY_LENGTH, (r == 0) ? 64'd0 : (r == 1) ? 64'd32 :
              (r == 2) ? 64'd63 : {$urandom, $urandom});
   endtask

   initial begin
      int r, n;
      key_reg = '{default: 64'd0};
      key_len_reg = hmacs_pkg::KeyLengthReset;
      in_message = 0;
      byte_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset key, empty message, single extreme bytes
      add_item(8'h00, 0, 1);
      add_item(8'h00, 1, 1);
      add_item(8'hff, 1, 1);
      wait_idle();
      for (int i = 0; i < 4; i++) csr_put(hmacs_pkg::csr_index_type'(i), '1);
      csr_put(hmacs_pkg::CSR_KEY_LENGTH, 64'd63);
      csr_put(hmacs_pkg::csr_index_type'(3'd5), 64'hdead);
      // no-byte items at the start and in the middle, last without a byte
      add_item(8'h12, 0, 0);
      add_item(8'ha5, 1, 0);
      add_item(8'h34, 0, 0);
      add_item(8'h5a, 1, 1);
      add_item(8'h7e, 1, 0);
      add_item(8'h99, 0, 1);
      wait_idle();
      csr_put(hmacs_pkg::CSR_KEY_LENGTH, 64'd0);
      add_item(8'h3c, 1, 1);
      add_item(8'h00, 0, 1);
      wait_idle();
      csr_put(hmacs_pkg::CSR_KEY_LENGTH, 64'd17);
      // key rewritten between the first and the last transaction
      add_item(8'h11, 1, 0);
      add_item(8'h22, 1, 0);
      wait_idle();
      csr_put(hmacs_pkg::CSR_KEY_WORD_0, 64'h0123456789abcdef);
      csr_put(hmacs_pkg::CSR_KEY_LENGTH, 64'd33);
      add_item(8'h33, 1, 1);
      wait_idle();

      while (items_queued < ItemTarget) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            wait_idle();
            random_key();
            if ($urandom_range(0, 7) == 0)
               csr_put(hmacs_pkg::csr_index_type'($urandom_range(5, 7)),
                       {$urandom, $urandom});
         end
         quiet_tx = ($urandom_range(0, 3) == 0);
         quiet_rx = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         n = (r < 65) ? $urandom_range(0, 20) :
             (r < 95) ? $urandom_range(50, 70) : $urandom_range(110, 130);
         if ($urandom_range(0, 19) == 0 && n > 2) begin
            for (int i = 0; i < n / 2; i++) add_item(8'($urandom), 1, 0);
            wait_idle();
            random_key();
            add_message(n - n / 2, 5);
         end else begin
            add_message(n, (r < 20) ? 30 : 3);
         end
         // with a chance of 1 in 25, the sender holds off until every MAC is back
         if ($urandom_range(0, 24) == 0) wait_idle();
      end

      while (pending_items.size() > 0 || req_valid || mac_queue.size() > 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
